/* rtl/fmpr_pkg.sv */
// Shared types, constants and register map of the flow meter rate block.
`default_nettype none

package fmpr_pkg;

  // Parameter defaults
  localparam int unsigned TOTAL_WIDTH_DEF = 48;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // Field widths
  localparam int unsigned PPL_W     = 12;
  localparam int unsigned LPS_W     = 8;
  localparam int unsigned ALPHA_W   = 3;
  localparam int unsigned STEPS_W   = 32;
  localparam int unsigned PULSE_W   = 32;
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned RATE_W    = 24;
  localparam int unsigned VOL_W     = 40;
  localparam int unsigned DUE_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Derived arithmetic widths
  localparam int unsigned USMIN_W    = 26;                  // 60e6 fits in 26 bits
  localparam int unsigned STEP_W     = PPL_W + LPS_W;       // pulses per step
  localparam int unsigned RATE_NUM_W = PULSE_W + USMIN_W;   // pulses * 60e6
  localparam int unsigned DEN_W      = ELAPSED_W + PPL_W;   // elapsed * ppl
  localparam int unsigned REST_W     = STEPS_W + STEP_W;    // restored * step

  // Constants
  localparam logic [USMIN_W-1:0] US_PER_MIN = 26'd60000000;
  localparam logic [RATE_W-1:0]  RATE_MAX   = '1;
  localparam logic [VOL_W-1:0]   VOL_MAX    = '1;
  localparam logic [DUE_W-1:0]   DUE_MAX    = '1;
  localparam logic [STEPS_W-1:0] STEPS_MAX  = '1;

  // Register reset values
  localparam logic [PPL_W-1:0]   PPL_RST   = 12'd270;
  localparam logic [LPS_W-1:0]   LPS_RST   = 8'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 3'd2;
  localparam logic [STEPS_W-1:0] REST_RST  = 32'd0;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PPL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST  = 2'd3;

  // Input kinds carried in tuser
  localparam logic CMD_PULSE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Sample job queue
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [PPL_W-1:0]   ppl;
    logic [LPS_W-1:0]   lps;
    logic [ALPHA_W-1:0] alpha;
    logic [STEPS_W-1:0] restored;
  } cfg_t;

  typedef struct packed {
    logic [PULSE_W-1:0]   pulses;
    logic [ELAPSED_W-1:0] elapsed;
  } job_t;

  // Result beat, first field in the highest bits
  typedef struct packed {
    logic [PULSE_W-1:0] sample_pulses;
    logic [DUE_W-1:0]   steps_due;
    logic [VOL_W-1:0]   total_volume;
    logic [RATE_W-1:0]  flow_raw;
    logic [RATE_W-1:0]  flow_smoothed;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

`default_nettype wire

/* rtl/fmpr_fifo.sv */
// Short job queue between the classifying front and the sample engine.
`default_nettype none

module fmpr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  fmpr_pkg::job_t     push_data,
  output logic               full,
  input  wire logic          pop,
  output fmpr_pkg::job_t     pop_data,
  output logic               empty
);

  localparam int unsigned DEPTH = fmpr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fmpr_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/fmpr_front.sv */
// Input side: counts pulse beats, turns sample beats into queued jobs.
`default_nettype none

module fmpr_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [fmpr_pkg::ELAPSED_W-1:0]    s_tdata,   // [31:0] period_us
  input  wire logic                              s_tuser,   // [0] cmd
  output logic                                   q_push,
  output fmpr_pkg::job_t                         q_data,
  input  wire logic                              q_full
);

  logic [fmpr_pkg::PULSE_W-1:0] pending;
  logic                         take;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;
  assign q_push   = take && (s_tuser == fmpr_pkg::CMD_SAMPLE);

  always_comb begin
    q_data.pulses  = pending;
    q_data.elapsed = s_tdata;
  end

  // Count pulses, hand the period's count to the queue on a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (take) begin
      if (s_tuser == fmpr_pkg::CMD_SAMPLE) begin
        pending <= '0;
      end else if (pending != '1) begin
        pending <= pending + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fmpr_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module fmpr_div #(
  parameter int unsigned NUM_W = 66,
  parameter int unsigned DEN_W = 44
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem, work[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dreg};
  assign ge      = (rem_sh >= {1'b0, dreg});
  assign quot    = work;

  // Shift in one numerator bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
        work   <= num;
        dreg   <= den;
        rem    <= '0;
      end else if (active) begin
        rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        work <= {work[NUM_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fmpr_back.sv */
// Sample engine: totals, persist steps, raw and smoothed rate, volume.
`default_nettype none

module fmpr_back #(
  parameter int unsigned TOTAL_WIDTH = fmpr_pkg::TOTAL_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = fmpr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  fmpr_pkg::cfg_t                     cfg,
  input  wire logic                          q_empty,
  input  fmpr_pkg::job_t                     q_data,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [fmpr_pkg::RES_W-1:0]         m_tdata
);

  localparam int unsigned NUM_W = ((TOTAL_WIDTH > fmpr_pkg::RATE_NUM_W) ?
                                   TOTAL_WIDTH : fmpr_pkg::RATE_NUM_W) + FRAC_BITS;
  localparam int unsigned RW    = (TOTAL_WIDTH > fmpr_pkg::REST_W) ?
                                  TOTAL_WIDTH : fmpr_pkg::REST_W;
  localparam int unsigned DEN_W = fmpr_pkg::DEN_W;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RESTORE, S_ACCUM,
    S_TGT_GO, S_TGT_WAIT, S_RATE_GO, S_RATE_WAIT,
    S_VOL_GO, S_VOL_WAIT, S_EMA, S_OUT
  } state_t;

  state_t                              state;
  fmpr_pkg::job_t                      job;
  logic [TOTAL_WIDTH-1:0]              total;
  logic [fmpr_pkg::STEPS_W-1:0]        persisted;
  logic [fmpr_pkg::RATE_W-1:0]         ema;
  logic                                started;
  logic [fmpr_pkg::STEP_W-1:0]         step;
  logic [fmpr_pkg::RATE_NUM_W-1:0]     rate_num;
  logic [DEN_W-1:0]                    rate_den;
  logic [fmpr_pkg::RATE_W-1:0]         raw;
  logic [fmpr_pkg::VOL_W-1:0]          vol;
  logic [fmpr_pkg::DUE_W-1:0]          due;
  fmpr_pkg::res_t                      res;

  logic [fmpr_pkg::PPL_W-1:0]          ppl_eff;
  logic [fmpr_pkg::LPS_W-1:0]          lps_eff;
  logic [fmpr_pkg::REST_W-1:0]         rest_prod;
  logic [RW-1:0]                       rest_ext;
  logic [TOTAL_WIDTH-1:0]              rest_sat;
  logic [TOTAL_WIDTH:0]                acc_sum;
  logic [NUM_W-1:0]                    diff;
  logic [31:0]                         ema_acc;
  logic [31:0]                         ema_ext;
  logic                                out_free;

  logic                                div_start;
  logic [NUM_W-1:0]                    div_num;
  logic [DEN_W-1:0]                    div_den;
  logic                                div_done;
  logic [NUM_W-1:0]                    div_quot;

  fmpr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Zero pulses_per_liter and liters_per_step count as one
  assign ppl_eff = (cfg.ppl == '0) ? fmpr_pkg::PPL_W'(1) : cfg.ppl;
  assign lps_eff = (cfg.lps == '0) ? fmpr_pkg::LPS_W'(1) : cfg.lps;

  // Restore total from persisted steps, saturated
  assign rest_prod = {{fmpr_pkg::STEP_W{1'b0}}, cfg.restored} *
                     {{fmpr_pkg::STEPS_W{1'b0}}, step};
  assign rest_ext  = RW'(rest_prod);
  assign rest_sat  = (rest_ext > RW'(TOTAL_MAX)) ? TOTAL_MAX : rest_ext[TOTAL_WIDTH-1:0];

  // Accumulate the period's pulses, saturated
  assign acc_sum = {1'b0, total} + (TOTAL_WIDTH + 1)'(job.pulses);

  // Persist step difference
  assign diff = div_quot - NUM_W'(persisted);

  // EMA: (raw + ema*(2^s - 1)) >> s
  assign ema_ext = 32'(ema);
  assign ema_acc = 32'(raw) + (ema_ext << cfg.alpha) - ema_ext;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign m_tdata  = res;

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(total);
    div_den   = DEN_W'(step);
    case (state)
      S_TGT_GO: begin
        div_start = 1'b1;
      end
      S_RATE_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(rate_num) << FRAC_BITS;
        div_den   = rate_den;
      end
      S_VOL_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(total) << FRAC_BITS;
        div_den   = DEN_W'(ppl_eff);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequence one sample job
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      persisted <= '0;
      ema       <= '0;
      started   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // Load a new result beat or drop the accepted one
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          step     <= {{fmpr_pkg::LPS_W{1'b0}}, ppl_eff} *
                      {{fmpr_pkg::PPL_W{1'b0}}, lps_eff};
          rate_num <= {{fmpr_pkg::USMIN_W{1'b0}}, job.pulses} *
                      {{fmpr_pkg::PULSE_W{1'b0}}, fmpr_pkg::US_PER_MIN};
          rate_den <= {{fmpr_pkg::PPL_W{1'b0}}, job.elapsed} *
                      {{fmpr_pkg::ELAPSED_W{1'b0}}, ppl_eff};
          state    <= S_RESTORE;
        end
        S_RESTORE: begin
          if (!started) begin
            total     <= rest_sat;
            persisted <= cfg.restored;
          end
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          total <= acc_sum[TOTAL_WIDTH] ? TOTAL_MAX : acc_sum[TOTAL_WIDTH-1:0];
          state <= S_TGT_GO;
        end
        S_TGT_GO: begin
          state <= S_TGT_WAIT;
        end
        S_TGT_WAIT: begin
          if (div_done) begin
            if (div_quot > NUM_W'(persisted)) begin
              due       <= (diff > NUM_W'(fmpr_pkg::DUE_MAX)) ? fmpr_pkg::DUE_MAX :
                                                               diff[fmpr_pkg::DUE_W-1:0];
              persisted <= (div_quot > NUM_W'(fmpr_pkg::STEPS_MAX)) ? fmpr_pkg::STEPS_MAX :
                                                                     div_quot[31:0];
            end else begin
              due <= '0;
            end
            if (job.elapsed == '0) begin
              raw   <= '0;
              state <= S_VOL_GO;
            end else begin
              state <= S_RATE_GO;
            end
          end
        end
        S_RATE_GO: begin
          state <= S_RATE_WAIT;
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            raw   <= (div_quot > NUM_W'(fmpr_pkg::RATE_MAX)) ? fmpr_pkg::RATE_MAX :
                                                              div_quot[fmpr_pkg::RATE_W-1:0];
            state <= S_VOL_GO;
          end
        end
        S_VOL_GO: begin
          state <= S_VOL_WAIT;
        end
        S_VOL_WAIT: begin
          if (div_done) begin
            vol   <= (div_quot > NUM_W'(fmpr_pkg::VOL_MAX)) ? fmpr_pkg::VOL_MAX :
                                                             div_quot[fmpr_pkg::VOL_W-1:0];
            state <= S_EMA;
          end
        end
        S_EMA: begin
          if (!started) begin
            ema     <= raw;
            started <= 1'b1;
          end else begin
            ema <= fmpr_pkg::RATE_W'(ema_acc >> cfg.alpha);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            res.flow_smoothed <= ema;
            res.flow_raw      <= raw;
            res.total_volume  <= vol;
            res.steps_due     <= due;
            res.sample_pulses <= job.pulses;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  a_persist_mono: assert property (@(posedge clk) disable iff (rst)
    started |=> persisted >= $past(persisted))
    else $error("persisted step count went backwards");

  a_raw_zero_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMA && job.elapsed == '0) |-> raw == '0)
    else $error("nonzero raw rate for zero elapsed time");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_TGT_WAIT || state == S_RATE_WAIT || state == S_VOL_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

/* rtl/flow_meter_pulse_rate_ema_core.sv */
// Top level of the pulse flow meter with smoothed rate output.
//
// Input channel s_*: tuser carries cmd (0 = one sensor pulse edge, 1 = sample
// tick), tdata carries period_us for a sample. Pulse beats are counted and
// give no result. A sample beat closes the period and queues a job; each
// sample gives one result beat on m_*.
// The engine works on one sample at a time, using the single shared divider,
// which yields one quotient bit per cycle and runs for persist target, raw
// rate and volume in turn; the rate division is skipped when period_us is
// zero. The divider width NUM_W is max(TOTAL_WIDTH, 58) + FRAC_BITS. Pulse
// beats are taken every cycle while the two-entry job queue has room.
// Config: cfg_we writes cfg_data into register cfg_index (0 pulses_per_liter,
// 1 liters_per_step, 2 alpha_shift, 3 restored_steps); write only while idle.
// Reset clears all counters, totals, the smoothed rate and the started flag
// and loads register defaults. When the receiver stalls, the result is held
// in the output register; the engine then waits, the queue fills and s_tready
// drops.
`default_nettype none

module flow_meter_pulse_rate_ema_core #(
  parameter int unsigned TOTAL_WIDTH = fmpr_pkg::TOTAL_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = fmpr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [fmpr_pkg::ELAPSED_W-1:0]     s_tdata,   // [31:0] period_us
  input  wire logic                               s_tuser,   // [0] cmd
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [23:0] flow_smoothed, [47:24] flow_raw, [87:48] total_volume,
  // [103:88] steps_due, [135:104] sample_pulses
  output logic [fmpr_pkg::RES_W-1:0]              m_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [fmpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fmpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fmpr_pkg::cfg_t cfg;
  fmpr_pkg::job_t push_data;
  fmpr_pkg::job_t pop_data;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ppl      <= fmpr_pkg::PPL_RST;
      cfg.lps      <= fmpr_pkg::LPS_RST;
      cfg.alpha    <= fmpr_pkg::ALPHA_RST;
      cfg.restored <= fmpr_pkg::REST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fmpr_pkg::REG_PPL:   cfg.ppl      <= cfg_data[fmpr_pkg::PPL_W-1:0];
        fmpr_pkg::REG_LPS:   cfg.lps      <= cfg_data[fmpr_pkg::LPS_W-1:0];
        fmpr_pkg::REG_ALPHA: cfg.alpha    <= cfg_data[fmpr_pkg::ALPHA_W-1:0];
        fmpr_pkg::REG_REST:  cfg.restored <= cfg_data[fmpr_pkg::STEPS_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  fmpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (push),
    .q_data   (push_data),
    .q_full   (full)
  );

  fmpr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  fmpr_back #(
    .TOTAL_WIDTH (TOTAL_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
